[src/bsbcd_pkg.sv]
// Package for the signed binary to packed BCD converter.
// Holds widths, sign nibble codes, the controller/datapath structs and
// the elaboration-time range helper. No dependencies.
package bsbcd_pkg;

  // Fixed word width of the input and of the packed result
  localparam int DATA_W = 32;

  // Default number of decimal digit nibbles
  localparam int DIGITS_DEF = 7;

  // Sign nibble codes
  localparam logic [3:0] SIGN_POS = 4'hC;
  localparam logic [3:0] SIGN_NEG = 4'hD;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input request
    logic check;  // take magnitude, test zero and range
    logic step;   // one shift-and-add-3 iteration
    logic last;   // final iteration: write the packed word
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic special;  // zero or out of range: result is the input pattern
  } status_t;

  // Largest magnitude that fits in the given number of digits (10^d - 1)
  function automatic logic [DATA_W-1:0] max_mag(input int digits);
    logic [DATA_W-1:0] lim;
    lim = 1;
    for (int k = 0; k < digits; k++) begin
      lim = DATA_W'(lim * 10);
    end
    return DATA_W'(lim - 1);
  endfunction

endpackage

[src/bsbcd_ctrl.sv]
// Controller for the signed binary to packed BCD converter.
// Sequences capture, range check and the shift-and-add-3 iterations.
// Depends on bsbcd_pkg.
module bsbcd_ctrl #(
  parameter int MAG_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bsbcd_pkg::status_t status,
  output bsbcd_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import bsbcd_pkg::*;

  localparam int CNT_W = $clog2(MAG_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Next state and iteration count
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        cnt_next  = '0;
        if (status.special) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.step = 1'b1;
        if (cnt == CNT_LAST) begin
          cmd.last   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

[src/bsbcd_dp.sv]
// Datapath for the signed binary to packed BCD converter.
// Input pattern register, magnitude shifter, BCD digit register, result.
// Depends on bsbcd_pkg.
module bsbcd_dp #(
  parameter int DIGITS   = bsbcd_pkg::DIGITS_DEF,
  parameter int MAG_BITS = 24
) (
  input  logic                             clk,
  input  bsbcd_pkg::cmd_t                  cmd,
  input  logic signed [bsbcd_pkg::DATA_W-1:0] value,
  output bsbcd_pkg::status_t               status,
  output logic [bsbcd_pkg::DATA_W-1:0]     packed_res
);
  import bsbcd_pkg::*;

  localparam int BCD_W = 4 * DIGITS;
  localparam logic [DATA_W-1:0] MAX_MAG = max_mag(DIGITS);

  logic [DATA_W-1:0]   pattern;
  logic [DATA_W-1:0]   abs_val;
  logic [MAG_BITS-1:0] mag;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;
  logic [BCD_W-1:0]    bcd_next;
  logic                neg;
  logic [DATA_W-1:0]   word;

  // Magnitude and special-case test on the captured pattern
  assign abs_val = pattern[DATA_W-1] ? (DATA_W'(0) - pattern) : pattern;
  assign status.special = (pattern == '0) || (abs_val > MAX_MAG);

  // Add 3 to every digit of 5 or more, then shift in the next magnitude bit
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
    bcd_next = {bcd_adj[BCD_W-2:0], mag[MAG_BITS-1]};
  end

  // Packed word: sign nibble low, digits above, unused nibbles zero
  always_comb begin
    word = '0;
    word[3:0] = neg ? SIGN_NEG : SIGN_POS;
    word[4 +: BCD_W] = bcd_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pattern <= $unsigned(value);
    end
    if (cmd.check) begin
      // Zero and out-of-range both return the pattern as is
      packed_res <= pattern;
      mag        <= abs_val[MAG_BITS-1:0];
      bcd        <= '0;
      neg        <= pattern[DATA_W-1];
    end
    if (cmd.step) begin
      bcd <= bcd_next;
      mag <= {mag[MAG_BITS-2:0], 1'b0};
    end
    if (cmd.last) begin
      packed_res <= word;
    end
  end

endmodule

[src/binary_to_signed_packed_bcd.sv]
// Top level of the signed binary to packed BCD converter.
// Joins the controller and the datapath. Depends on bsbcd_pkg,
// bsbcd_ctrl and bsbcd_dp.
//
//   Channel   Ports                 Handshake
//   --------  --------------------  ----------------------------------
//   request   start, value          taken when start=1 and busy=0
//   result    done, packed_res      valid for the one cycle done=1
//
// Each request goes from acceptance through a range-check state, one
// shift-and-add-3 iteration per magnitude bit in the loop, then the
// done state. Zero and out-of-range inputs skip the loop and go from
// the range check straight to the done state.
// busy rises after acceptance and stays high through the done cycle.
// Reset (rst, synchronous) returns the controller to idle.
// The result cannot be held off; it is shown for exactly one cycle.
module binary_to_signed_packed_bcd #(
  parameter int DIGITS = bsbcd_pkg::DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [bsbcd_pkg::DATA_W-1:0] value,
  output logic                                busy,
  output logic                                done,
  output logic [bsbcd_pkg::DATA_W-1:0]        packed_res
);
  import bsbcd_pkg::*;

  // Magnitude bits needed for the largest in-range value
  localparam int MAG_BITS = $clog2(max_mag(DIGITS) + 1);

  cmd_t    cmd;
  status_t status;

  bsbcd_ctrl #(
    .MAG_BITS (MAG_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bsbcd_dp #(
    .DIGITS   (DIGITS),
    .MAG_BITS (MAG_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .value      (value),
    .status     (status),
    .packed_res (packed_res)
  );

endmodule
